FILE: hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and the 4B5B code table for the line encoder.
// ----------------------------------------------------------------------------
package sle_pkg;

   // coding mode held in the control register
   typedef enum logic [1:0] {
      LC_NRZ        = 2'd0,
      LC_MANCHESTER = 2'd1,
      LC_NRZI       = 2'd2,
      LC_4B5B       = 2'd3
   } line_code_type;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CODED_W    = 16;  // widest coded group (manchester)
   localparam int unsigned WIDTH_W    = 5;   // holds a coded group width up to 16
   localparam int unsigned PEND_W     = 7;   // leftover bits between items
   localparam int unsigned PCNT_W     = 3;
   localparam int unsigned ACC_W      = PEND_W + CODED_W;
   localparam int unsigned QUEUE_DEPTH = 2;

   // one coded item handed from the front to the back
   typedef struct packed {
      logic [CODED_W-1:0] coded;   // right aligned
      logic [WIDTH_W-1:0] width;   // number of valid coded bits
      logic               last;
   } queue_entry_type;

   function automatic logic [4:0] code_4b5b(input logic [3:0] nibble);
      logic [4:0] sym;
      case (nibble)
         4'h0: sym = 5'h1E;
         4'h1: sym = 5'h09;
         4'h2: sym = 5'h14;
         4'h3: sym = 5'h15;
         4'h4: sym = 5'h0A;
         4'h5: sym = 5'h0B;
         4'h6: sym = 5'h0E;
         4'h7: sym = 5'h0F;
         4'h8: sym = 5'h12;
         4'h9: sym = 5'h13;
         4'hA: sym = 5'h16;
         4'hB: sym = 5'h17;
         4'hC: sym = 5'h1A;
         4'hD: sym = 5'h1B;
         4'hE: sym = 5'h1C;
         4'hF: sym = 5'h1D;
         default: sym = 5'h1E;
      endcase
      return sym;
   endfunction

endpackage

FILE: hw/rtl/selectable_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// selectable_line_encoder_unit
// Line encoder for message bytes: NRZ, Manchester, NRZI or 4B5B coding,
// packed msb first into output bytes with zero padding at message end.
//
//   port group  direction  handshake           payload
//   req_        in         req_valid/req_stall data_byte, last_byte
//   rsp_        out        rsp_valid/rsp_stall coded_byte, last_out
//   csr_        in         csr_write_en        write_data (line code)
//
// One output byte leaves per cycle while rsp_stall is low; an item yielding two
// bytes (manchester, some 4B5B bytes, a padded tail) keeps its second byte in
// the hold register, and the next item is not taken from the queue until that
// byte has moved on. Coded bytes are registered in the output register.
// Reset is synchronous; the queue lets input transfers continue for two
// items while the output side is stalled.
// ----------------------------------------------------------------------------
module selectable_line_encoder_unit #(
   parameter int unsigned QueueDepth = sle_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_coded_byte,
   output logic       rsp_last_out
);
   import sle_pkg::*;

   logic            push, pop, q_full, q_empty;
   queue_entry_type push_entry, head_entry;

   sle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .q_full         (q_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   sle_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   sle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .flush          (csr_write_en),
      .q_empty        (q_empty),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_coded_byte (rsp_coded_byte),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

FILE: hw/rtl/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front
// Takes message bytes, holds the mode register and the NRZI level, and
// turns each byte into a right-aligned coded group for the queue.
// ----------------------------------------------------------------------------
module sle_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   input  logic                     q_full,
   output logic                     push,
   output sle_pkg::queue_entry_type push_entry
);
   import sle_pkg::*;

   line_code_type mode_ff, mode_in;
   logic          level_ff, level_in;
   logic [7:0]    nrzi_bits;
   logic          lvl;
   logic [CODED_W-1:0] manch;
   logic          accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   // level after each bit, msb first
   always_comb begin
      lvl = level_ff;
      nrzi_bits = '0;
      for (int i = 7; i >= 0; i--) begin
         lvl = lvl ^ req_data_byte[i];
         nrzi_bits[i] = lvl;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         manch[2*i+1] = req_data_byte[i];
         manch[2*i]   = !req_data_byte[i];
      end
   end

   always_comb begin
      push_entry.last  = req_last_byte;
      case (mode_ff)
         LC_MANCHESTER: begin
            push_entry.coded = manch;
            push_entry.width = WIDTH_W'(16);
         end
         LC_NRZI: begin
            push_entry.coded = CODED_W'(nrzi_bits);
            push_entry.width = WIDTH_W'(8);
         end
         LC_4B5B: begin
            push_entry.coded = CODED_W'({code_4b5b(req_data_byte[7:4]),
                                         code_4b5b(req_data_byte[3:0])});
            push_entry.width = WIDTH_W'(10);
         end
         default: begin
            push_entry.coded = CODED_W'(req_data_byte);
            push_entry.width = WIDTH_W'(8);
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      level_in = level_ff;
      if (csr_write_en) begin
         mode_in  = line_code_type'(csr_write_data);
         level_in = 1'b0;
      end else if (accept) begin
         // level restarts at zero for each message
         level_in = req_last_byte ? 1'b0 : ((mode_ff == LC_NRZI) ? lvl : level_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= LC_NRZ;
         level_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         level_ff <= level_in;
      end
   end

endmodule

FILE: hw/rtl/sle_queue.sv
// ----------------------------------------------------------------------------
// sle_queue
// Small register queue of coded groups between the front and the back.
// ----------------------------------------------------------------------------
module sle_queue #(
   parameter int unsigned Depth = sle_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sle_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output sle_pkg::queue_entry_type head_entry,
   output logic                     full,
   output logic                     empty
);
   import sle_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   queue_entry_type       slots_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back
// Packs coded groups behind the leftover bits, sends whole bytes msb first
// and pads the final byte of a message with zeros.
// ----------------------------------------------------------------------------
module sle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     flush,
   input  logic                     q_empty,
   input  sle_pkg::queue_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_coded_byte,
   output logic                     rsp_last_out
);
   import sle_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [7:0]         hold_byte_ff, hold_byte_in;
   logic               hold_last_ff, hold_last_in;
   logic [PEND_W-1:0]  pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]  pend_cnt_ff, pend_cnt_in;

   logic               slot_free;
   logic [ACC_W-1:0]   acc;
   logic [ACC_W+7:0]   acc_ext;
   logic [WIDTH_W-1:0] cnt, rem1, rem2;
   logic               two_full, pad, two_out;
   logic [7:0]         byte0, byte1;
   logic [PEND_W-1:0]  keep_mask;

   assign rsp_valid      = out_valid_ff;
   assign rsp_coded_byte = out_byte_ff;
   assign rsp_last_out   = out_last_ff;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign pop       = slot_free && !hold_valid_ff && !q_empty;

   // leftover bits shifted above the new group
   always_comb begin
      acc      = (ACC_W'(pend_bits_ff) << head_entry.width) | ACC_W'(head_entry.coded);
      acc_ext  = {acc, 8'h00};
      cnt      = WIDTH_W'(pend_cnt_ff) + head_entry.width;
      rem1     = cnt - WIDTH_W'(8);
      two_full = (rem1 >= WIDTH_W'(8));
      pad      = head_entry.last && (rem1 != '0) && !two_full;
      two_out  = two_full || pad;
      byte0    = acc_ext[cnt +: 8];
      // a short remainder lands in the top bits with zeros below
      byte1    = acc_ext[rem1 +: 8];
      rem2     = two_full ? (rem1 - WIDTH_W'(8)) : rem1;
      keep_mask = PEND_W'((8'd1 << rem2[PCNT_W-1:0]) - 8'd1);
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_last_in  = hold_last_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      if (slot_free) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = hold_byte_ff;
            out_last_in   = hold_last_ff;
            hold_valid_in = 1'b0;
         end else if (!q_empty) begin
            out_valid_in  = 1'b1;
            out_byte_in   = byte0;
            out_last_in   = head_entry.last && !two_out;
            hold_valid_in = two_out;
            hold_byte_in  = byte1;
            hold_last_in  = head_entry.last;
            if (head_entry.last) begin
               pend_bits_in = '0;
               pend_cnt_in  = '0;
            end else begin
               pend_bits_in = acc[PEND_W-1:0] & keep_mask;
               pend_cnt_in  = rem2[PCNT_W-1:0];
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (flush) begin
         pend_bits_in = '0;
         pend_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
         pend_cnt_ff   <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      hold_byte_ff <= hold_byte_in;
      hold_last_ff <= hold_last_in;
   end

endmodule
